@@ src/resonant_lowpass_highpass_chain_defines.svh @@
// Assertion macros for the resonant low-pass / high-pass chain checker.
`ifndef RESONANT_LOWPASS_HIGHPASS_CHAIN_DEFINES_SVH
`define RESONANT_LOWPASS_HIGHPASS_CHAIN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLHC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rlhc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLHC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rlhc check failed");

`endif

@@ src/rlhc_pkg.sv @@
// Types, constants and arithmetic helpers for the resonant filter chain.
`timescale 1ns / 1ps

package rlhc_pkg;

  localparam int CHANNELS_DEFAULT = 2;
  localparam int CFG_CH     = 2;   // channels that have their own gain registers

  localparam int RAW_W      = 32;
  localparam int SAMPLE_W   = 23;
  localparam int STATE_W    = 24;
  localparam int RES_W      = 8;
  localparam int GAIN_W     = 9;
  localparam int LIMIT_W    = 22;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 22;

  localparam int MUL_A_W    = 25;
  localparam int MUL_B_W    = 10;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int QUOT_W     = PROD_W - 8;
  localparam int ACC_W      = QUOT_W + 1;

  localparam logic [GAIN_W-1:0]  GAIN_UNITY  = GAIN_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_RES_CH0,
    CFG_RES_CH1,
    CFG_LPG_CH0,
    CFG_LPG_CH1,
    CFG_HPG_CH0,
    CFG_HPG_CH1,
    CFG_DELTA_LIM,
    CFG_SAMPLE_LIM
  } cfg_idx_t;

  typedef struct packed {
    logic                    channel;
    logic signed [RAW_W-1:0] raw_sample;
    logic                    buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic                       out_channel;
    logic                       out_buffer_end;
  } out_item_t;

  // Divide a product by 256, truncating toward zero.
  function automatic logic signed [QUOT_W-1:0] div256(input logic signed [PROD_W-1:0] p);
    logic signed [QUOT_W-1:0] q;
    q = QUOT_W'(p >>> 8);
    if (p[PROD_W-1] && (p[7:0] != 8'd0)) begin
      q = q + QUOT_W'(1);
    end
    return q;
  endfunction

  // Limit v to [-lim, lim].
  function automatic logic signed [STATE_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                          input logic [LIMIT_W-1:0] lim);
    logic signed [ACC_W-1:0] l;
    logic signed [ACC_W-1:0] r;
    l = signed'({{(ACC_W-LIMIT_W){1'b0}}, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return STATE_W'(r);
  endfunction

endpackage

@@ src/resonant_lowpass_highpass_chain.sv @@
// Top level: resonant low-pass followed by one-pole high-pass, per channel.
`timescale 1ns / 1ps
//
// Channel  Direction  Handshake             Beat
// in_      input      in_valid / in_ready   channel, raw_sample, buffer_end
// out_     output     out_valid / out_ready filtered_sample, out_channel, out_buffer_end
// cfg_     input      cfg_we                cfg_addr selects register, cfg_wdata value
//
// One sample runs from the accept cycle through seven sequencer steps (RES, LPG, CLD,
// LPN, HPD, HPM, HPC). The pace is set by the single 25x10 multiplier, which forms the
// resonance, low-pass and high-pass products in turn, and by the clamp steps between them.
// in_ready is high only while the sequencer is idle. A stalled result holds the last
// step until the output register frees. Reset clears filter state and loads register
// defaults at once; no clearing pass.

module resonant_lowpass_highpass_chain #(
  parameter int CHANNELS = rlhc_pkg::CHANNELS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rlhc_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rlhc_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  logic [rlhc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [rlhc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RES,
    ST_LPG,
    ST_CLD,
    ST_LPN,
    ST_HPD,
    ST_HPM,
    ST_HPC
  } state_t;

  state_t state_r;

  // Configuration
  logic [rlhc_pkg::RES_W-1:0]   res_r [rlhc_pkg::CFG_CH];
  logic [rlhc_pkg::GAIN_W-1:0]  lpg_r [rlhc_pkg::CFG_CH];
  logic [rlhc_pkg::GAIN_W-1:0]  hpg_r [rlhc_pkg::CFG_CH];
  logic [rlhc_pkg::LIMIT_W-1:0] dlim_r;
  logic [rlhc_pkg::LIMIT_W-1:0] slim_r;

  // Per-channel filter state
  logic signed [rlhc_pkg::STATE_W-1:0] lp_r [CHANNELS];
  logic signed [rlhc_pkg::STATE_W-1:0] dl_r [CHANNELS];
  logic signed [rlhc_pkg::STATE_W-1:0] hp_r [CHANNELS];

  // Working registers
  logic [CH_W-1:0]                     ch_r;
  logic                                chin_r;
  logic                                bend_r;
  logic signed [rlhc_pkg::RAW_W-1:0]   raw_r;
  logic signed [rlhc_pkg::ACC_W-1:0]   acc_r;
  logic signed [rlhc_pkg::MUL_A_W-1:0] diff_r;
  logic signed [rlhc_pkg::MUL_A_W-1:0] hpre_r;
  logic signed [rlhc_pkg::MUL_A_W-1:0] mop_r;
  logic signed [rlhc_pkg::STATE_W-1:0] delta_new_r;
  logic signed [rlhc_pkg::STATE_W-1:0] lpn_r;
  logic                                out_valid_r;
  rlhc_pkg::out_item_t                 out_data_r;

  logic [CH_W-1:0]                     ch_sel;
  logic                                cfg_ch;
  logic signed [rlhc_pkg::STATE_W-1:0] lp_cur;
  logic signed [rlhc_pkg::STATE_W-1:0] dl_cur;
  logic signed [rlhc_pkg::STATE_W-1:0] hp_cur;
  logic signed [rlhc_pkg::SAMPLE_W-1:0] x_w;
  logic signed [rlhc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [rlhc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [rlhc_pkg::PROD_W-1:0]  prod;
  logic signed [rlhc_pkg::QUOT_W-1:0]  quot;
  logic signed [rlhc_pkg::STATE_W-1:0] hp_new;
  logic                                out_free;

  // Channels beyond the last one fold onto the last one.
  assign ch_sel = (32'(in_data.channel) < CHANNELS) ? CH_W'(in_data.channel)
                                                    : CH_W'(CHANNELS - 1);
  assign cfg_ch = 1'(ch_r);

  assign lp_cur = lp_r[ch_r];
  assign dl_cur = dl_r[ch_r];
  assign hp_cur = hp_r[ch_r];

  // Scale by 1/512, truncating toward zero.
  assign x_w = rlhc_pkg::SAMPLE_W'(raw_r >>> 9)
             + {{(rlhc_pkg::SAMPLE_W-1){1'b0}},
                (raw_r[rlhc_pkg::RAW_W-1] && (raw_r[8:0] != 9'd0))};

  // Shared multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_RES: begin
        mul_a = rlhc_pkg::MUL_A_W'(dl_cur);
        mul_b = signed'({2'b00, res_r[cfg_ch]});
      end
      ST_LPG: begin
        mul_a = diff_r;
        mul_b = signed'({1'b0, lpg_r[cfg_ch]});
      end
      ST_HPM: begin
        mul_a = mop_r;
        mul_b = signed'({1'b0, hpg_r[cfg_ch]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = rlhc_pkg::PROD_W'(mul_a) * rlhc_pkg::PROD_W'(mul_b);
  assign quot     = rlhc_pkg::div256(prod);
  assign hp_new   = rlhc_pkg::clamp_sym(acc_r, slim_r);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < rlhc_pkg::CFG_CH; k++) begin
        res_r[k] <= '0;
        lpg_r[k] <= rlhc_pkg::GAIN_UNITY;
        hpg_r[k] <= rlhc_pkg::GAIN_UNITY;
      end
      dlim_r <= rlhc_pkg::LIMIT_RESET;
      slim_r <= rlhc_pkg::LIMIT_RESET;
      for (int k = 0; k < CHANNELS; k++) begin
        lp_r[k] <= '0;
        dl_r[k] <= '0;
        hp_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (rlhc_pkg::cfg_idx_t'(cfg_addr))
          rlhc_pkg::CFG_RES_CH0:    res_r[0] <= cfg_wdata[rlhc_pkg::RES_W-1:0];
          rlhc_pkg::CFG_RES_CH1:    res_r[1] <= cfg_wdata[rlhc_pkg::RES_W-1:0];
          rlhc_pkg::CFG_LPG_CH0:    lpg_r[0] <= cfg_wdata[rlhc_pkg::GAIN_W-1:0];
          rlhc_pkg::CFG_LPG_CH1:    lpg_r[1] <= cfg_wdata[rlhc_pkg::GAIN_W-1:0];
          rlhc_pkg::CFG_HPG_CH0:    hpg_r[0] <= cfg_wdata[rlhc_pkg::GAIN_W-1:0];
          rlhc_pkg::CFG_HPG_CH1:    hpg_r[1] <= cfg_wdata[rlhc_pkg::GAIN_W-1:0];
          rlhc_pkg::CFG_DELTA_LIM:  dlim_r   <= cfg_wdata[rlhc_pkg::LIMIT_W-1:0];
          rlhc_pkg::CFG_SAMPLE_LIM: slim_r   <= cfg_wdata[rlhc_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // drop the beat once taken, unless the last step refills the register
      if (out_valid_r && out_ready && (state_r != ST_HPC)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            ch_r    <= ch_sel;
            chin_r  <= in_data.channel;
            bend_r  <= in_data.buffer_end;
            raw_r   <= in_data.raw_sample;
            state_r <= ST_RES;
          end
        end
        ST_RES: begin
          // decayed delta; prepare the low-pass and high-pass differences
          acc_r   <= rlhc_pkg::ACC_W'(quot);
          diff_r  <= rlhc_pkg::MUL_A_W'(x_w) - rlhc_pkg::MUL_A_W'(lp_cur);
          hpre_r  <= rlhc_pkg::MUL_A_W'(hp_cur) - rlhc_pkg::MUL_A_W'(lp_cur);
          state_r <= ST_LPG;
        end
        ST_LPG: begin
          acc_r   <= acc_r + rlhc_pkg::ACC_W'(quot);
          state_r <= ST_CLD;
        end
        ST_CLD: begin
          delta_new_r <= rlhc_pkg::clamp_sym(acc_r, dlim_r);
          state_r     <= ST_LPN;
        end
        ST_LPN: begin
          lpn_r   <= rlhc_pkg::clamp_sym(rlhc_pkg::ACC_W'(lp_cur)
                                         + rlhc_pkg::ACC_W'(delta_new_r), slim_r);
          state_r <= ST_HPD;
        end
        ST_HPD: begin
          mop_r   <= hpre_r + rlhc_pkg::MUL_A_W'(lpn_r);
          state_r <= ST_HPM;
        end
        ST_HPM: begin
          acc_r   <= rlhc_pkg::ACC_W'(quot);
          state_r <= ST_HPC;
        end
        ST_HPC: begin
          // hold here until the output register can take the beat
          if (out_free) begin
            dl_r[ch_r] <= delta_new_r;
            lp_r[ch_r] <= lpn_r;
            hp_r[ch_r] <= hp_new;
            out_data_r.filtered_sample <= rlhc_pkg::SAMPLE_W'(hp_new);
            out_data_r.out_channel     <= chin_r;
            out_data_r.out_buffer_end  <= bend_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/rlhc_checker.sv @@
// Port-level checker for the resonant filter chain, bound to the top level.
`timescale 1ns / 1ps
`include "resonant_lowpass_highpass_chain_defines.svh"

module rlhc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input rlhc_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input rlhc_pkg::out_item_t out_data
);

  logic last_ch_r;
  logic last_be_r;
  logic echo_ok;

  // Remember the sideband of the most recent accepted beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      last_ch_r <= in_data.channel;
      last_be_r <= in_data.buffer_end;
    end
  end

  assign echo_ok = (out_data.out_channel == last_ch_r) &&
                   (out_data.out_buffer_end == last_be_r);

  `RLHC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `RLHC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `RLHC_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid))
  `RLHC_ASSERT_SAME(a_sideband_echo, $rose(out_valid), echo_ok)

endmodule

bind resonant_lowpass_highpass_chain rlhc_checker u_rlhc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ sim/testbench.sv @@
// Self-checking testbench for the resonant low-pass / high-pass filter chain.
`timescale 1ns / 1ps

module testbench;
  import rlhc_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_MAX    = 10;
  localparam int NUM_REGS      = 8;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Filter state and register copies, per channel
  longint lp_state [2];
  longint delta_state [2];
  longint hp_state [2];
  longint resonance [2];
  longint lp_gain [2];
  longint hp_gain [2];
  longint delta_lim;
  longint sample_lim;

  logic [CFG_DATA_W-1:0] cfg_next [NUM_REGS];
  out_item_t             filtered_queue [$];
  logic signed [31:0]    slow_raw [2];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int cycle_count   = 0;

  resonant_lowpass_highpass_chain DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic longint clamp_to(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance one channel's low-pass and high-pass stages by one sample.
  function automatic out_item_t filter_step(input in_item_t it);
    int        c;
    longint    x;
    longint    lp_old;
    longint    d;
    longint    lp_new;
    longint    hp;
    out_item_t r;
    c = (int'(it.channel) < CHANNELS_DEFAULT) ? int'(it.channel) : CHANNELS_DEFAULT - 1;
    x = longint'($signed(it.raw_sample)) / 512;
    lp_old = lp_state[c];
    d = (delta_state[c] * resonance[c]) / 256 + ((x - lp_old) * lp_gain[c]) / 256;
    d = clamp_to(d, delta_lim);
    lp_new = clamp_to(lp_old + d, sample_lim);
    hp = clamp_to(((hp_state[c] + lp_new - lp_old) * hp_gain[c]) / 256, sample_lim);
    delta_state[c] = d;
    lp_state[c] = lp_new;
    hp_state[c] = hp;
    r.filtered_sample = hp[SAMPLE_W-1:0];
    r.out_channel = it.channel;
    r.out_buffer_end = it.buffer_end;
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(5))
      0:       return '0;
      1, 2:    return LIMIT_RESET;
      3:       return CFG_DATA_W'($urandom_range(4095, 1));
      default: return CFG_DATA_W'($urandom_range(4194303));
    endcase
  endfunction

  // Fill cfg_next with a random setting; upper bits above each resonance and gain register carry noise.
  function automatic void pick_random_config();
    int v;
    for (int k = 0; k < 2; k++) begin
      case ($urandom_range(3))
        0:       v = 0;
        1:       v = 255;
        default: v = $urandom_range(255);
      endcase
      cfg_next[CFG_RES_CH0 + k] = {14'($urandom), 8'(v)};
      for (int g = 0; g < 2; g++) begin
        case ($urandom_range(4))
          0:       v = 0;
          1:       v = 256;
          2:       v = 511;
          default: v = $urandom_range(511);
        endcase
        cfg_next[CFG_LPG_CH0 + 2 * g + k] = {13'($urandom), 9'(v)};
      end
    end
    cfg_next[CFG_DELTA_LIM] = pick_limit();
    cfg_next[CFG_SAMPLE_LIM] = pick_limit();
  endfunction

  function automatic in_item_t random_sample();
    in_item_t it;
    it.channel = 1'($urandom);
    it.buffer_end = ($urandom_range(15) == 0);
    case ($urandom_range(9))
      0, 1, 2, 3: it.raw_sample = $urandom;
      4, 5:       it.raw_sample = int'($urandom_range(131071)) - 65536;
      6: begin
        case ($urandom_range(3))
          0:       it.raw_sample = 32'h7FFF_FFFF;
          1:       it.raw_sample = 32'h8000_0000;
          2:       it.raw_sample = '0;
          default: it.raw_sample = '1;
        endcase
      end
      default: begin
        // slowly moving signal so the filters track instead of saturating
        slow_raw[it.channel] = slow_raw[it.channel] + (int'($urandom_range(2097152)) - 1048576);
        it.raw_sample = slow_raw[it.channel];
      end
    endcase
    return it;
  endfunction

  task automatic apply_config();
    cfg_idx_t r;
    for (int k = 0; k < NUM_REGS; k++) begin
      r = cfg_idx_t'(k);
      cfg_we <= 1'b1;
      cfg_addr <= r;
      cfg_wdata <= cfg_next[k];
      @(posedge clk);
      case (r)
        CFG_RES_CH0:    resonance[0] = longint'(cfg_next[k][RES_W-1:0]);
        CFG_RES_CH1:    resonance[1] = longint'(cfg_next[k][RES_W-1:0]);
        CFG_LPG_CH0:    lp_gain[0] = longint'(cfg_next[k][GAIN_W-1:0]);
        CFG_LPG_CH1:    lp_gain[1] = longint'(cfg_next[k][GAIN_W-1:0]);
        CFG_HPG_CH0:    hp_gain[0] = longint'(cfg_next[k][GAIN_W-1:0]);
        CFG_HPG_CH1:    hp_gain[1] = longint'(cfg_next[k][GAIN_W-1:0]);
        CFG_DELTA_LIM:  delta_lim = longint'(cfg_next[k][LIMIT_W-1:0]);
        CFG_SAMPLE_LIM: sample_lim = longint'(cfg_next[k][LIMIT_W-1:0]);
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  // Offer one beat; valid stays high after acceptance until the caller drops it.
  task automatic send_sample(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    filtered_queue.push_back(filter_step(it));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (filtered_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    in_item_t    it;
    logic [31:0] raws [12] = '{32'h0000_0000, 32'h0000_01FF, 32'h0000_0200, 32'hFFFF_FE01,
                               32'hFFFF_FE00, 32'hFFFF_FDFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_5555};
    for (int k = 0; k < 12; k++) begin
      it.channel = (k >= 6);
      it.raw_sample = raws[k];
      it.buffer_end = k[0];
      send_sample(it);
    end
  endtask

  task automatic test_config_extremes();
    in_item_t    it;
    logic [31:0] raws [8] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                              32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF, 32'hAAAA_AAAA};
    wait_for_results();
    // gains from zero to above unity and strong resonance, with tight clamps
    cfg_next[CFG_RES_CH0] = 22'd255;
    cfg_next[CFG_RES_CH1] = 22'd128;
    cfg_next[CFG_LPG_CH0] = 22'd511;
    cfg_next[CFG_LPG_CH1] = 22'd256;
    cfg_next[CFG_HPG_CH0] = 22'd511;
    cfg_next[CFG_HPG_CH1] = 22'd0;
    cfg_next[CFG_DELTA_LIM] = 22'd3000;
    cfg_next[CFG_SAMPLE_LIM] = 22'd5000;
    apply_config();
    for (int k = 0; k < 8; k++) begin
      it.channel = k[0];
      it.raw_sample = raws[k];
      it.buffer_end = k[1];
      send_sample(it);
    end
    wait_for_results();
    // zero limits pin every output at zero
    cfg_next[CFG_DELTA_LIM] = '0;
    cfg_next[CFG_SAMPLE_LIM] = '0;
    apply_config();
    for (int k = 0; k < 3; k++) begin
      it.channel = k[0];
      it.raw_sample = raws[k];
      it.buffer_end = 1'b1;
      send_sample(it);
    end
  endtask

  task automatic test_backpressure();
    wait_for_results();
    pick_random_config();
    apply_config();
    hold_requests <= hold_requests + 1;
    for (int k = 0; k < 40; k++) send_sample(random_sample());
    // pause the sender until every result is back, then resume
    wait_for_results();
    for (int k = 0; k < 20; k++) send_sample(random_sample());
  endtask

  task automatic test_random_traffic(input int batches, input int per_batch);
    for (int b = 0; b < batches; b++) begin
      wait_for_results();
      pick_random_config();
      apply_config();
      for (int k = 0; k < per_batch; k++) send_sample(random_sample());
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (filtered_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected beat: sample %0d channel %0b end %0b",
                   out_data.filtered_sample, out_data.out_channel, out_data.out_buffer_end);
        end
      end else begin
        want = filtered_queue.pop_front();
        if (out_data.filtered_sample !== want.filtered_sample ||
            out_data.out_channel !== want.out_channel ||
            out_data.out_buffer_end !== want.out_buffer_end) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch: sample exp %0d got %0d, ch exp %0b got %0b, end exp %0b got %0b",
                     want.filtered_sample, out_data.filtered_sample,
                     want.out_channel, out_data.out_channel,
                     want.out_buffer_end, out_data.out_buffer_end);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[resonant_lowpass_highpass_chain] ERROR");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < 2; c++) begin
      lp_state[c] = 0;
      delta_state[c] = 0;
      hp_state[c] = 0;
      resonance[c] = 0;
      lp_gain[c] = longint'(GAIN_UNITY);
      hp_gain[c] = longint'(GAIN_UNITY);
      slow_raw[c] = '0;
    end
    delta_lim = longint'(LIMIT_RESET);
    sample_lim = longint'(LIMIT_RESET);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_config_extremes();
    test_backpressure();
    send_idle_pct = 32;
    recv_idle_pct = 78;
    test_random_traffic(4, 160);
    send_idle_pct = 78;
    recv_idle_pct = 32;
    test_random_traffic(4, 160);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(4, 155);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[resonant_lowpass_highpass_chain] OK");
    end else begin
      $display("[resonant_lowpass_highpass_chain] ERROR");
    end
    $finish;
  end

endmodule
